/* hw/rtl/rawm_pkg.sv */
package rawm_pkg;

    // Default store sizes and window limit.
    localparam int QUERY_DEPTH    = 4096;
    localparam int DATABASE_DEPTH = 65536;
    localparam int ALPHABET_SIZE  = 256;
    localparam int MAX_WINDOW     = 64;

    // Fixed field widths of the stream payload.
    localparam int ADDR_W = 16;
    localparam int SYM_W  = 8;
    localparam int QC_W   = 12;
    localparam int DC_W   = 16;
    localparam int DIST_W = 7;
    localparam int WLEN_W = 7;

    localparam logic [WLEN_W-1:0] WINDOW_RESET = 7'd16;

    // Request kinds carried in the input tuser.
    typedef enum logic [1:0] {
        OP_LOAD_QUERY = 2'd0,
        OP_LOAD_DB    = 2'd1,
        OP_LOAD_MAP   = 2'd2,
        OP_COMPUTE    = 2'd3
    } t_opcode;

    // Compute command handed to the window controller.
    typedef struct packed {
        logic [WLEN_W-1:0] wlen;
        logic [DC_W-1:0]   dc;
        logic [QC_W-1:0]   qc;
    } t_cmd;

    // Result word, laid out as the output tdata (distance in the low bits).
    typedef struct packed {
        logic              out_of_range;
        logic [DIST_W-1:0] distance;
    } t_result;

endpackage

/* hw/rtl/reduced_alphabet_window_mismatch.sv */
// Load requests (query symbol, database symbol, map entry) are taken back to back, one per
// cycle, while no compute is in progress. A compute request first checks the window placement,
// then reads L symbol pairs, L being the window length saturated to MAX_WINDOW: one symbol pair
// is read per cycle, then mapped and compared. A window that does not fit, or a zero length,
// skips the reads. The input is held off until the result enters the output register.
// Synchronous active-low reset sets the window length to 16; stores stay undefined until written.
module reduced_alphabet_window_mismatch #(
    parameter int QUERY_DEPTH    = rawm_pkg::QUERY_DEPTH,
    parameter int DATABASE_DEPTH = rawm_pkg::DATABASE_DEPTH,
    parameter int ALPHABET_SIZE  = rawm_pkg::ALPHABET_SIZE,
    parameter int MAX_WINDOW     = rawm_pkg::MAX_WINDOW
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: window length.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    // address [15:0], symbol [23:16], query_center [35:24],
    // db_center [51:36], zero fill [55:52]
    input  logic [55:0] s_tdata,
    // opcode [1:0]
    input  logic [1:0]  s_tuser,
    // Output stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    // distance [6:0], out_of_range [7]
    output logic [7:0]  m_tdata
);

    localparam int QAW = $clog2(QUERY_DEPTH);
    localparam int DAW = $clog2(DATABASE_DEPTH);
    localparam int MAW = $clog2(ALPHABET_SIZE);

    logic [rawm_pkg::WLEN_W-1:0] r_window_length;
    logic                        r_m_valid;
    rawm_pkg::t_result           r_m_data;

    rawm_pkg::t_opcode           w_opcode;
    logic [rawm_pkg::ADDR_W-1:0] w_address;
    logic [rawm_pkg::SYM_W-1:0]  w_symbol;
    logic                        w_accept;
    logic                        w_busy;
    logic                        w_we_q, w_we_d, w_we_m;
    rawm_pkg::t_cmd              w_cmd;
    logic                        w_res_valid, w_res_ready;
    rawm_pkg::t_result           w_res;

    logic                        w_q_re, w_d_re, w_m_re;
    logic [QAW-1:0]              w_q_raddr;
    logic [DAW-1:0]              w_d_raddr;
    logic [MAW-1:0]              w_mq_raddr, w_md_raddr;
    logic [rawm_pkg::SYM_W-1:0]  w_q_rdata, w_d_rdata, w_mq_rdata, w_md_rdata;

    // Unpack the request.
    assign w_opcode  = rawm_pkg::t_opcode'(s_tuser);
    assign w_address = s_tdata[15:0];
    assign w_symbol  = s_tdata[23:16];
    assign w_cmd.qc  = s_tdata[35:24];
    assign w_cmd.dc  = s_tdata[51:36];
    assign w_cmd.wlen = r_window_length;

    assign s_tready = !w_busy;
    assign w_accept = s_tvalid && s_tready;

    // Load requests write straight into the stores; out-of-range addresses are dropped.
    assign w_we_q = w_accept && (w_opcode == rawm_pkg::OP_LOAD_QUERY)
                    && (32'(w_address) < 32'(QUERY_DEPTH));
    assign w_we_d = w_accept && (w_opcode == rawm_pkg::OP_LOAD_DB)
                    && (32'(w_address) < 32'(DATABASE_DEPTH));
    assign w_we_m = w_accept && (w_opcode == rawm_pkg::OP_LOAD_MAP)
                    && (32'(w_address) < 32'(ALPHABET_SIZE));

    // Window length register.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= rawm_pkg::WINDOW_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_window_length <= i_cfg_data;
        end
    end

    rawm_sym_mem #(.DEPTH(QUERY_DEPTH)) u_query_mem (
        .i_clk   (i_clk),
        .i_we    (w_we_q),
        .i_waddr (QAW'(w_address)),
        .i_wdata (w_symbol),
        .i_re    (w_q_re),
        .i_raddr (w_q_raddr),
        .o_rdata (w_q_rdata)
    );

    rawm_sym_mem #(.DEPTH(DATABASE_DEPTH)) u_db_mem (
        .i_clk   (i_clk),
        .i_we    (w_we_d),
        .i_waddr (DAW'(w_address)),
        .i_wdata (w_symbol),
        .i_re    (w_d_re),
        .i_raddr (w_d_raddr),
        .o_rdata (w_d_rdata)
    );

    rawm_code_map #(.DEPTH(ALPHABET_SIZE)) u_code_map (
        .i_clk     (i_clk),
        .i_we      (w_we_m),
        .i_waddr   (MAW'(w_address)),
        .i_wdata   (w_symbol),
        .i_re      (w_m_re),
        .i_raddr_q (w_mq_raddr),
        .i_raddr_d (w_md_raddr),
        .o_rdata_q (w_mq_rdata),
        .o_rdata_d (w_md_rdata)
    );

    rawm_window_ctl #(
        .QUERY_DEPTH    (QUERY_DEPTH),
        .DATABASE_DEPTH (DATABASE_DEPTH),
        .ALPHABET_SIZE  (ALPHABET_SIZE),
        .MAX_WINDOW     (MAX_WINDOW)
    ) u_window_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_accept && (w_opcode == rawm_pkg::OP_COMPUTE)),
        .i_cmd       (w_cmd),
        .o_busy      (w_busy),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_q_re      (w_q_re),
        .o_q_raddr   (w_q_raddr),
        .i_q_rdata   (w_q_rdata),
        .o_d_re      (w_d_re),
        .o_d_raddr   (w_d_raddr),
        .i_d_rdata   (w_d_rdata),
        .o_m_re      (w_m_re),
        .o_mq_raddr  (w_mq_raddr),
        .o_md_raddr  (w_md_raddr),
        .i_mq_rdata  (w_mq_rdata),
        .i_md_rdata  (w_md_rdata)
    );

    // Output register decouples the result from the downstream stall.
    assign w_res_ready = !r_m_valid || m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_m_valid <= 1'b1;
        end else if (m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_m_data <= w_res;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;

    // A window that does not fit always reports zero distance.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tdata[rawm_pkg::DIST_W]) |-> (m_tdata[rawm_pkg::DIST_W-1:0] == '0))
        else $error("out-of-range result carries a nonzero distance");

    // A compute request occupies the block on the following cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_opcode == rawm_pkg::OP_COMPUTE)) |=> !s_tready)
        else $error("input accepted while a compute is in progress");

    // A finished result always lands in the output register.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && w_res_ready) |=> m_tvalid)
        else $error("result lost between controller and output register");

endmodule

/* hw/rtl/rawm_sym_mem.sv */
module rawm_sym_mem #(
    parameter int DEPTH = rawm_pkg::QUERY_DEPTH,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [rawm_pkg::SYM_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [AW-1:0]              i_raddr,
    output logic [rawm_pkg::SYM_W-1:0] o_rdata
);

    logic [rawm_pkg::SYM_W-1:0] r_mem [DEPTH];
    logic [rawm_pkg::SYM_W-1:0] r_rdata;

    // Single write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/rawm_code_map.sv */
module rawm_code_map #(
    parameter int DEPTH = rawm_pkg::ALPHABET_SIZE,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [rawm_pkg::SYM_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [AW-1:0]              i_raddr_q,
    input  logic [AW-1:0]              i_raddr_d,
    output logic [rawm_pkg::SYM_W-1:0] o_rdata_q,
    output logic [rawm_pkg::SYM_W-1:0] o_rdata_d
);

    logic [rawm_pkg::SYM_W-1:0] r_mem [DEPTH];
    logic [rawm_pkg::SYM_W-1:0] r_rdata_q;
    logic [rawm_pkg::SYM_W-1:0] r_rdata_d;

    // Map entries are written one at a time by load requests.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Two registered read ports: one for the query symbol, one for the database symbol.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_q <= r_mem[i_raddr_q];
            r_rdata_d <= r_mem[i_raddr_d];
        end
    end

    assign o_rdata_q = r_rdata_q;
    assign o_rdata_d = r_rdata_d;

endmodule

/* hw/rtl/rawm_window_ctl.sv */
module rawm_window_ctl #(
    parameter int QUERY_DEPTH    = rawm_pkg::QUERY_DEPTH,
    parameter int DATABASE_DEPTH = rawm_pkg::DATABASE_DEPTH,
    parameter int ALPHABET_SIZE  = rawm_pkg::ALPHABET_SIZE,
    parameter int MAX_WINDOW     = rawm_pkg::MAX_WINDOW,
    localparam int QAW = $clog2(QUERY_DEPTH),
    localparam int DAW = $clog2(DATABASE_DEPTH),
    localparam int MAW = $clog2(ALPHABET_SIZE)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  rawm_pkg::t_cmd             i_cmd,
    output logic                       o_busy,
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output rawm_pkg::t_result          o_res,
    output logic                       o_q_re,
    output logic [QAW-1:0]             o_q_raddr,
    input  logic [rawm_pkg::SYM_W-1:0] i_q_rdata,
    output logic                       o_d_re,
    output logic [DAW-1:0]             o_d_raddr,
    input  logic [rawm_pkg::SYM_W-1:0] i_d_rdata,
    output logic                       o_m_re,
    output logic [MAW-1:0]             o_mq_raddr,
    output logic [MAW-1:0]             o_md_raddr,
    input  logic [rawm_pkg::SYM_W-1:0] i_mq_rdata,
    input  logic [rawm_pkg::SYM_W-1:0] i_md_rdata
);

    localparam int LEN_W = $clog2(MAX_WINDOW + 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CHECK = 4'b0010,
        ST_RUN   = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

    t_state                       r_state, n_state;
    logic [rawm_pkg::QC_W-1:0]    r_qc;
    logic [rawm_pkg::DC_W-1:0]    r_dc;
    logic [LEN_W-1:0]             r_len;
    logic                         r_bad;
    logic [QAW-1:0]               r_qpos;
    logic [DAW-1:0]               r_dpos;
    logic [LEN_W-1:0]             r_issue;
    logic                         r_v1, r_v2;
    logic [rawm_pkg::SYM_W-1:0]   r_qsym_d, r_dsym_d;
    logic                         r_qin_d, r_din_d;
    logic [rawm_pkg::DIST_W-1:0]  r_dist;

    logic [31:0]                  w_half, w_qstart, w_dstart;
    logic                         w_q_ok, w_d_ok, w_bad;
    logic                         w_issue;
    logic                         w_qin, w_din;
    logic [rawm_pkg::SYM_W-1:0]   w_red_q, w_red_d;
    logic [LEN_W-1:0]             w_len_sat;

    // Length saturated to the largest supported window.
    assign w_len_sat = (32'(i_cmd.wlen) > 32'(MAX_WINDOW)) ? LEN_W'(MAX_WINDOW)
                                                           : LEN_W'(i_cmd.wlen);

    // Window placement check: start = center - len/2, and start + len must fit.
    assign w_half   = 32'(r_len >> 1);
    assign w_qstart = 32'(r_qc) - w_half;
    assign w_dstart = 32'(r_dc) - w_half;
    assign w_q_ok   = (32'(r_qc) >= w_half) && (w_qstart + 32'(r_len) <= 32'(QUERY_DEPTH));
    assign w_d_ok   = (32'(r_dc) >= w_half) && (w_dstart + 32'(r_len) <= 32'(DATABASE_DEPTH));
    assign w_bad    = !w_q_ok || !w_d_ok;

    // One symbol pair is read from the stores per cycle while positions remain.
    assign w_issue   = (r_state == ST_RUN) && (r_issue != r_len);
    assign o_q_re    = w_issue;
    assign o_d_re    = w_issue;
    assign o_q_raddr = r_qpos;
    assign o_d_raddr = r_dpos;

    // Symbols outside the alphabet bypass the map and reduce to themselves.
    assign w_qin      = 32'(i_q_rdata) < 32'(ALPHABET_SIZE);
    assign w_din      = 32'(i_d_rdata) < 32'(ALPHABET_SIZE);
    assign o_m_re     = r_v1;
    assign o_mq_raddr = w_qin ? MAW'(i_q_rdata) : '0;
    assign o_md_raddr = w_din ? MAW'(i_d_rdata) : '0;

    assign w_red_q = r_qin_d ? i_mq_rdata : r_qsym_d;
    assign w_red_d = r_din_d ? i_md_rdata : r_dsym_d;

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                n_state = (w_bad || (r_len == '0)) ? ST_DONE : ST_RUN;
            end
            ST_RUN: begin
                if (!w_issue && !r_v1 && !r_v2) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_res_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= w_issue;
            r_v2    <= r_v1;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && i_start) begin
            r_qc  <= i_cmd.qc;
            r_dc  <= i_cmd.dc;
            r_len <= w_len_sat;
        end
        if (r_state == ST_CHECK) begin
            r_bad   <= w_bad;
            r_qpos  <= QAW'(w_qstart);
            r_dpos  <= DAW'(w_dstart);
            r_issue <= '0;
            r_dist  <= '0;
        end
        if (w_issue) begin
            r_issue <= r_issue + LEN_W'(1);
            r_qpos  <= r_qpos + QAW'(1);
            r_dpos  <= r_dpos + DAW'(1);
        end
        // Hold the raw symbols while the map lookup is in flight.
        if (r_v1) begin
            r_qsym_d <= i_q_rdata;
            r_dsym_d <= i_d_rdata;
            r_qin_d  <= w_qin;
            r_din_d  <= w_din;
        end
        // Count positions whose reduced codes differ.
        if (r_v2 && (w_red_q != w_red_d)) begin
            r_dist <= r_dist + rawm_pkg::DIST_W'(1);
        end
    end

    assign o_busy             = (r_state != ST_IDLE);
    assign o_res_valid        = (r_state == ST_DONE);
    assign o_res.out_of_range = r_bad;
    assign o_res.distance     = r_bad ? '0 : r_dist;

endmodule
